@@ design/mpwmd_pkg.sv @@
// Shared types and constants for the multichannel PWM / delay driver.
package mpwmd_pkg;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int CHAN_W    = 3;
  localparam int VALUE_W   = 16;
  localparam int MODE_REG_W   = 10;
  localparam int INV_REG_W    = 5;
  localparam int PERIOD_REG_W = 16;
  localparam int PERIOD_REGS  = 5;

  localparam logic [2:0] REG_MODES       = 3'd0;
  localparam logic [2:0] REG_INVERT      = 3'd1;
  localparam logic [2:0] REG_PERIOD0     = 3'd2;
  localparam logic [2:0] REG_PERIOD_LAST = 3'd6;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ARM_ON   = 2'd1,
    OP_ARM_OFF  = 2'd2,
    OP_LOAD_CMP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SWITCH = 2'd1,
    MODE_PWM    = 2'd2
  } mode_t;

  // Per-channel command strobes, already qualified by the stage advance.
  typedef struct packed {
    logic tick;
    logic arm_on;
    logic arm_off;
    logic load_cmp;
  } cmd_t;

endpackage

@@ design/multichannel_pwm_delay_driver_core.sv @@
// Top level of the multichannel PWM / delay driver: input stage, channels, result, APB registers.
// Timing: an accepted beat waits in the input register and is applied at the edge at which
//   it leaves it; its pin_levels result is valid from that edge on.
// Throughput: one beat per cycle unless stalled; all channels update in parallel from the
//   input register, which lets one more beat in while a result is stalled at the output.
// Reset (rst, synchronous): all channel state and on bits cleared, modes set to switch,
//   invert mask and periods cleared, both stages empty.
module multichannel_pwm_delay_driver_core
  import mpwmd_pkg::*;
#(
  parameter int CHANNELS    = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHANNELS-1:0] pin_levels
);

  // configuration registers
  logic [2*CHANNELS-1:0]  channel_modes;
  logic [CHANNELS-1:0]    invert_mask;
  logic [COUNT_WIDTH-1:0] period [CHANNELS];
  logic                   cfg_write;
  logic [2:0]             cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_modes <= {CHANNELS{MODE_SWITCH}};
      invert_mask   <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_MODES)
        channel_modes <= (2*CHANNELS)'(pwdata[MODE_REG_W-1:0]);
      if (cfg_index == REG_INVERT)
        invert_mask <= CHANNELS'(pwdata[INV_REG_W-1:0]);
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_period
    if (c < PERIOD_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          period[c] <= '0;
        end else if (cfg_write && cfg_index == REG_PERIOD0 + 3'(c)) begin
          period[c] <= COUNT_WIDTH'(pwdata[PERIOD_REG_W-1:0]);
        end
      end
    end else begin : g_none
      assign period[c] = '0;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_index) inside
      REG_MODES:  prdata = DATA_W'(channel_modes);
      REG_INVERT: prdata = DATA_W'(invert_mask);
      [REG_PERIOD0:REG_PERIOD_LAST]: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (cfg_index - REG_PERIOD0 == 3'(c))
            prdata = DATA_W'(period[c]);
        end
      end
      default: prdata = '0;
    endcase
  end

  // input register
  logic               s1_valid;
  op_t                s1_op;
  logic [CHAN_W-1:0]  s1_channel;
  logic [VALUE_W-1:0] s1_value;
  logic               s1_adv;
  logic               in_accept;

  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op      <= op_t'(op);
      s1_channel <= channel;
      s1_value   <= value;
    end
  end

  // channels
  logic [CHANNELS-1:0] ch_on;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    cmd_t cmd;
    logic sel;

    assign sel          = s1_adv && s1_channel == CHAN_W'(c);
    assign cmd.tick     = s1_adv && s1_op == OP_TICK;
    assign cmd.arm_on   = sel && s1_op == OP_ARM_ON;
    assign cmd.arm_off  = sel && s1_op == OP_ARM_OFF;
    assign cmd.load_cmp = sel && s1_op == OP_LOAD_CMP;

    mpwmd_channel #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_channel (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .value (COUNT_WIDTH'(s1_value)),
      .mode  (mode_t'(channel_modes[2*c +: 2])),
      .period(period[c]),
      .on    (ch_on[c])
    );
  end

  // result: channel on bits are the state after the last applied beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign pin_levels = ch_on ^ invert_mask;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted beat missing from input register");

  a_stalled_stage_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input register dropped a beat that was not applied");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("applied beat produced no result");

endmodule

@@ design/mpwmd_channel.sv @@
// One output channel: delay counters, PWM counter, compare value and on state.
module mpwmd_channel
  import mpwmd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [COUNT_WIDTH-1:0] value,
  input  mode_t                  mode,
  input  logic [COUNT_WIDTH-1:0] period,
  output logic                   on
);

  logic [COUNT_WIDTH-1:0] pwm_counter, pwm_counter_next;
  logic [COUNT_WIDTH-1:0] compare_value, compare_value_next;
  logic [COUNT_WIDTH-1:0] on_delay, on_delay_next;
  logic [COUNT_WIDTH-1:0] off_delay, off_delay_next;
  logic                   on_next;
  logic [COUNT_WIDTH-1:0] cnt;

  always_comb begin
    pwm_counter_next   = pwm_counter;
    compare_value_next = compare_value;
    on_delay_next      = on_delay;
    off_delay_next     = off_delay;
    on_next            = on;
    cnt                = (pwm_counter >= period) ? '0 : pwm_counter;
    if (cmd.tick) begin
      case (mode)
        MODE_SWITCH: begin
          if (on_delay != '0) begin
            on_delay_next = on_delay - COUNT_WIDTH'(1);
            if (on_delay == COUNT_WIDTH'(1)) begin
              on_next        = 1'b1;
              off_delay_next = '0;
            end
          end
          // off delay sees the value left by the turn-on above
          if (off_delay_next != '0) begin
            if (off_delay_next == COUNT_WIDTH'(1)) begin
              on_next       = 1'b0;
              on_delay_next = '0;
            end
            off_delay_next = off_delay_next - COUNT_WIDTH'(1);
          end
        end
        MODE_PWM: begin
          if (cnt >= compare_value) begin
            on_next       = 1'b0;
            on_delay_next = '0;
          end else begin
            on_next        = 1'b1;
            off_delay_next = '0;
          end
          pwm_counter_next = cnt + COUNT_WIDTH'(1);
        end
        default: begin
          // off and the unused code: channel holds
        end
      endcase
    end
    if (cmd.arm_on)   on_delay_next      = value;
    if (cmd.arm_off)  off_delay_next     = value;
    if (cmd.load_cmp) compare_value_next = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_counter   <= '0;
      compare_value <= '0;
      on_delay      <= '0;
      off_delay     <= '0;
      on            <= 1'b0;
    end else begin
      pwm_counter   <= pwm_counter_next;
      compare_value <= compare_value_next;
      on_delay      <= on_delay_next;
      off_delay     <= off_delay_next;
      on            <= on_next;
    end
  end

  a_on_clears_off_delay: assert property (@(posedge clk) disable iff (rst)
    $rose(on) |-> off_delay == '0)
    else $error("channel turned on with a pending off delay");

  a_off_clears_on_delay: assert property (@(posedge clk) disable iff (rst)
    $fell(on) |-> on_delay == '0)
    else $error("channel turned off with a pending on delay");

  a_idle_mode_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.tick && mode != MODE_SWITCH && mode != MODE_PWM
      |=> $stable(on) && $stable(pwm_counter) && $stable(on_delay)
          && $stable(off_delay))
    else $error("channel in off mode changed on a tick");

endmodule

@@ bench/mpwmd_pin_checker.sv @@
// Pin-level predictor and checker for the multichannel PWM / delay driver.
module mpwmd_pin_checker
  import mpwmd_pkg::*;
#(
  parameter int CHANNELS    = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [VALUE_W-1:0]  value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [CHANNELS-1:0] pin_levels,
  output int                  errors,
  output int                  pending,
  output int                  beats_in,
  output int                  beats_out
);

  logic [2*CHANNELS-1:0]  modes;
  logic [CHANNELS-1:0]    invert;
  logic [COUNT_WIDTH-1:0] period    [CHANNELS];
  logic [COUNT_WIDTH-1:0] pwm_ramp  [CHANNELS];
  logic [COUNT_WIDTH-1:0] duty      [CHANNELS];
  logic [COUNT_WIDTH-1:0] on_wait   [CHANNELS];
  logic [COUNT_WIDTH-1:0] off_wait  [CHANNELS];
  logic [CHANNELS-1:0]    lit;
  logic [CHANNELS-1:0]    pins_due [$];

  task automatic clear_channels();
    for (int c = 0; c < CHANNELS; c++) begin
      modes[2*c +: 2] = MODE_SWITCH;
      period[c]    = '0;
      pwm_ramp[c]  = '0;
      duty[c]      = '0;
      on_wait[c]   = '0;
      off_wait[c]  = '0;
    end
    invert = '0;
    lit    = '0;
  endtask

  task automatic write_config(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    if (idx == REG_MODES) begin
      modes = (2*CHANNELS)'(data[MODE_REG_W-1:0]);
    end else if (idx == REG_INVERT) begin
      invert = CHANNELS'(data[INV_REG_W-1:0]);
    end else if (idx >= REG_PERIOD0 && idx <= REG_PERIOD_LAST) begin
      if (int'(idx - REG_PERIOD0) < CHANNELS)
        period[idx - REG_PERIOD0] = COUNT_WIDTH'(data[PERIOD_REG_W-1:0]);
    end
  endtask

  task automatic tick_channel(input int c);
    logic [1:0] m;
    m = modes[2*c +: 2];
    if (m == MODE_SWITCH) begin
      if (on_wait[c] != '0) begin
        on_wait[c] = on_wait[c] - COUNT_WIDTH'(1);
        if (on_wait[c] == '0) begin
          lit[c]      = 1'b1;
          off_wait[c] = '0;
        end
      end
      if (off_wait[c] != '0) begin
        off_wait[c] = off_wait[c] - COUNT_WIDTH'(1);
        if (off_wait[c] == '0) begin
          lit[c]     = 1'b0;
          on_wait[c] = '0;
        end
      end
    end else if (m == MODE_PWM) begin
      if (pwm_ramp[c] >= period[c]) pwm_ramp[c] = '0;
      if (pwm_ramp[c] >= duty[c]) begin
        lit[c]     = 1'b0;
        on_wait[c] = '0;
      end else begin
        lit[c]      = 1'b1;
        off_wait[c] = '0;
      end
      pwm_ramp[c] = pwm_ramp[c] + COUNT_WIDTH'(1);
    end
    // off and the unused mode code hold the channel
  endtask

  task automatic predict_pins(input op_t code, input logic [CHAN_W-1:0] chan,
                              input logic [VALUE_W-1:0] val);
    if (code == OP_TICK) begin
      for (int c = 0; c < CHANNELS; c++) tick_channel(c);
    end else if (chan < CHANNELS) begin
      case (code)
        OP_ARM_ON:   on_wait[chan]  = COUNT_WIDTH'(val);
        OP_ARM_OFF:  off_wait[chan] = COUNT_WIDTH'(val);
        OP_LOAD_CMP: duty[chan]     = COUNT_WIDTH'(val);
        default: ;
      endcase
    end
    pins_due.push_back(lit ^ invert);
  endtask

  initial begin
    errors    = 0;
    pending   = 0;
    beats_in  = 0;
    beats_out = 0;
    clear_channels();
  end

  always @(posedge clk) begin
    logic [CHANNELS-1:0] want;
    if (rst) begin
      clear_channels();
      pins_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_config(paddr[ADDR_W-1:2], pwdata);
      if (in_valid && !in_stall) begin
        beats_in++;
        predict_pins(op_t'(op), channel, value);
      end
      if (out_valid && !out_stall) begin
        beats_out++;
        if (pins_due.size() == 0) begin
          if (errors < 10) $display("ERROR: pin_levels %b arrived with no beat pending", pin_levels);
          errors++;
        end else begin
          want = pins_due.pop_front();
          if (want !== pin_levels) begin
            if (errors < 10)
              $display("ERROR: result %0d pin_levels expected %b got %b", beats_out, want,
                       pin_levels);
            errors++;
          end
        end
      end
    end
    pending = pins_due.size();
  end

endmodule

@@ bench/multichannel_pwm_delay_driver_core_tb.sv @@
// Stimulus and verdict for the multichannel PWM / delay driver core.
module multichannel_pwm_delay_driver_core_tb;
  import mpwmd_pkg::*;

  localparam int CHANNELS    = 5;
  localparam int COUNT_WIDTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 190;
  localparam logic [2:0] REG_UNMAPPED = REG_PERIOD_LAST + 3'd1;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op        = '0;
  logic [CHAN_W-1:0]   channel   = '0;
  logic [VALUE_W-1:0]  value     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CHANNELS-1:0] pin_levels;

  logic idle_on   = 1'b1;
  logic hold_now  = 1'b0;
  int   reg_writes = 0;
  int   cycles     = 0;
  int   errors, pending, beats_in, beats_out;

  always #5 clk = ~clk;

  multichannel_pwm_delay_driver_core #(
    .CHANNELS   (CHANNELS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .op, .channel, .value, .out_valid, .out_stall, .pin_levels
  );

  mpwmd_pin_checker #(
    .CHANNELS   (CHANNELS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .op, .channel, .value, .out_valid, .out_stall, .pin_levels,
    .errors, .pending, .beats_in, .beats_out
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Cycle limit hit with %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // valid stays up across back-to-back beats; it only drops for a gap or a drain
  task automatic send_beat(input op_t code, input logic [CHAN_W-1:0] chan,
                           input logic [VALUE_W-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    channel  <= chan;
    value    <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // drain all results before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_beat();
    op_t                code;
    logic [CHAN_W-1:0]  chan;
    logic [VALUE_W-1:0] val;
    code = ($urandom_range(0, 9) < 5) ? OP_TICK : op_t'($urandom_range(1, 3));
    chan = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom_range(5, 7))
                                       : CHAN_W'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = '1;
      2:       val = VALUE_W'($urandom);
      default: val = VALUE_W'($urandom_range(1, 20));
    endcase
    send_beat(code, chan, val);
  endtask

  task automatic random_config();
    logic [2*CHANNELS-1:0] m;
    logic [DATA_W-1:0]     p;
    int                    pick;
    for (int c = 0; c < CHANNELS; c++) begin
      pick = $urandom_range(0, 5);
      m[2*c +: 2] = (pick < 2) ? MODE_SWITCH : (pick < 4) ? MODE_PWM : 2'($urandom_range(0, 3));
    end
    write_reg(REG_MODES, DATA_W'(m));
    case ($urandom_range(0, 2))
      0:       write_reg(REG_INVERT, '0);
      1:       write_reg(REG_INVERT, DATA_W'(5'h1f));
      default: write_reg(REG_INVERT, DATA_W'($urandom_range(0, 31)));
    endcase
    for (int c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(0, 7))
        0:       p = '0;
        1:       p = DATA_W'(16'hffff);
        2:       p = DATA_W'($urandom_range(0, 65535));
        default: p = DATA_W'($urandom_range(1, 12));
      endcase
      write_reg(REG_PERIOD0 + 3'(c), p);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int len;
    forever begin
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 15);
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 15);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modes: every channel a delayed switch
    send_beat(OP_ARM_ON, 3'd0, 16'd1);
    send_beat(OP_TICK, 3'd0, 16'd0);
    send_beat(OP_ARM_ON, 3'd1, 16'd3);
    send_beat(OP_ARM_OFF, 3'd0, 16'd2);
    send_beat(OP_ARM_ON, 3'd2, 16'd5);
    send_beat(OP_ARM_ON, 3'd2, 16'd0);      // zero disarms
    send_beat(OP_ARM_OFF, 3'd3, 16'hffff);
    send_beat(OP_ARM_ON, 3'd4, 16'd1);
    send_beat(OP_ARM_OFF, 3'd4, 16'd1);     // both expire on one tick: the turn-on wins and clears the off delay
    send_beat(OP_ARM_ON, 3'd5, 16'h0001);   // out-of-range channels do nothing
    send_beat(OP_ARM_OFF, 3'd6, 16'haaaa);
    send_beat(OP_LOAD_CMP, 3'd7, 16'h5555);
    repeat (3) send_beat(OP_TICK, 3'd7, 16'hffff);
    drain();

    write_reg(REG_MODES, DATA_W'(10'h2aa));
    write_reg(REG_INVERT, DATA_W'(5'h1f));
    write_reg(REG_PERIOD0, '0);
    write_reg(REG_PERIOD0 + 3'd1, DATA_W'(16'd1));
    write_reg(REG_PERIOD0 + 3'd2, DATA_W'(16'd3));
    write_reg(REG_PERIOD0 + 3'd3, DATA_W'(16'd5));
    write_reg(REG_PERIOD_LAST, DATA_W'(16'hffff));
    write_reg(REG_UNMAPPED, '1);
    send_beat(OP_LOAD_CMP, 3'd0, 16'd1);    // period zero: on while compare nonzero
    send_beat(OP_LOAD_CMP, 3'd2, 16'd2);
    send_beat(OP_LOAD_CMP, 3'd4, 16'hffff);
    repeat (4) send_beat(OP_TICK, 3'd0, 16'd0);
    drain();
    write_reg(REG_MODES, DATA_W'(10'h3ff));  // unused code everywhere: all hold
    send_beat(OP_TICK, 3'd0, 16'd0);
    send_beat(OP_TICK, 3'd0, 16'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      random_config();
      if (ph == 1) hold_now = 1'b1;
      if (ph == PHASES - 1) idle_on = 1'b0;
      repeat (PHASE_BEATS) random_beat();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d beats and %0d pin results across %0d register writes,", beats_in,
             beats_out, reg_writes);
    $display("with off/switch/pwm/unused modes, inverted pins and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
